// File: hdl/rrpc_pkg.sv
// Shared types and constants for the round robin picker with cooldown.
// Used by the channel interfaces, the countdown bank, the top level and the checker.
// Depends on nothing.
package rrpc_pkg;

  // Sizing of the pool and of one countdown.
  localparam int MAX_ENTRIES = 16;
  localparam int TIMER_WIDTH = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths of the request, the result and the registers.
  localparam int REQ_W   = 2;
  localparam int ENTRY_W = 4;
  localparam int PICK_W  = 4;
  localparam int POOL_W  = 5;
  localparam int COOL_W  = 16;

  localparam logic [COOL_W-1:0]      COOLDOWN_RESET = COOL_W'(60);
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX      = '1;

  // Configuration port.
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_POOL_SIZE = 1'b0;
  localparam logic REG_COOLDOWN  = 1'b1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BANK_NOP,
    BANK_LOAD,
    BANK_DEC
  } bank_op_t;

  // One command to the countdown bank per cycle.
  typedef struct packed {
    bank_op_t               op;
    logic [IDX_W-1:0]       idx;
    logic [TIMER_WIDTH-1:0] load;
  } bank_cmd_t;

endpackage

// File: hdl/rrpc_if.sv
// Valid/ready channel interfaces for request words and result words.
// Depends on rrpc_pkg.
interface rrpc_req_if;
  import rrpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ENTRY_W-1:0] entry_index;
  modport source(output valid, output req_type, output entry_index, input ready);
  modport sink(input valid, input req_type, input entry_index, output ready);
endinterface

interface rrpc_res_if;
  import rrpc_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [PICK_W-1:0] picked_index;
  modport source(output valid, output found, output picked_index, input ready);
  modport sink(input valid, input found, input picked_index, output ready);
endinterface

// File: hdl/rrpc_cd_bank.sv
// Bank of per-entry countdowns with one shared load/decrement unit and a zero test.
// Depends on rrpc_pkg.
module rrpc_cd_bank (
  input  logic               clk,
  input  logic               rst_n,
  input  rrpc_pkg::bank_cmd_t cmd,
  output logic               rd_zero
);
  import rrpc_pkg::*;

  logic [TIMER_WIDTH-1:0] cd_r [MAX_ENTRIES];
  logic [TIMER_WIDTH-1:0] sel_val;
  logic [TIMER_WIDTH-1:0] entry_nxt;
  logic                   wr_en;

  assign sel_val = cd_r[cmd.idx];
  assign rd_zero = (sel_val == '0);

  // The single arithmetic unit: load or saturating-at-zero decrement.
  always_comb begin
    entry_nxt = sel_val;
    wr_en     = 1'b0;
    case (cmd.op)
      BANK_LOAD: begin
        entry_nxt = cmd.load;
        wr_en     = 1'b1;
      end
      BANK_DEC: begin
        entry_nxt = sel_val - TIMER_WIDTH'(1);
        wr_en     = !rd_zero;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        cd_r[i] <= '0;
      end
    end else if (wr_en) begin
      cd_r[cmd.idx] <= entry_nxt;
    end
  end

endmodule

// File: hdl/round_robin_picker_with_cooldown.sv
// Pick: an empty pool gets none found via the emit state; else a scan tests one countdown per
// cycle until it finds a zero or has tested every entry in the pool (a cursor beyond a shrunken
// pool is first cut by one subtract a cycle), and ST_EMIT holds the result until output is free.
// A mark loads its countdown and leaves the request channel ready; a tick holds it busy while
// every countdown is decremented, one per cycle through the shared unit. One request at a time.
// Reset (rst_n low, synchronous) clears countdowns and cursor at once; no clearing pass.
module round_robin_picker_with_cooldown (
  input  logic                          clk,
  input  logic                          rst_n,
  rrpc_req_if.sink                      in_req,
  rrpc_res_if.source                    out_res,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rrpc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [rrpc_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [rrpc_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import rrpc_pkg::*;

  localparam int SZ_W  = (CNT_W > POOL_W) ? CNT_W : POOL_W;
  localparam int CMP_W = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
  localparam int LD_W  = (TIMER_WIDTH > COOL_W) ? TIMER_WIDTH : COOL_W;

  // Configuration registers.
  logic [POOL_W-1:0] pool_size_r, pool_size_nxt;
  logic [COOL_W-1:0] cooldown_r, cooldown_nxt;

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  next_start_r, next_start_nxt;
  logic              res_found_r, res_found_nxt;
  logic [PICK_W-1:0] res_idx_r, res_idx_nxt;

  // Output register: lets a finished result wait while new requests are taken.
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [PICK_W-1:0] out_idx_r, out_idx_nxt;

  logic                   cfg_wr;
  logic                   reg_sel;
  logic [SZ_W-1:0]        pool_ext;
  logic [SZ_W-1:0]        size_clip;
  logic [CNT_W-1:0]       size;
  logic [LD_W-1:0]        load_ext;
  logic [TIMER_WIDTH-1:0] load_val;
  logic                   in_fire;
  logic                   entry_in_pool;
  logic [CNT_W-1:0]       pos_inc;
  logic [CNT_W-1:0]       pos_wrap;
  logic                   bank_zero;
  bank_cmd_t              bank_cmd;

  // APB-style register access; pready is tied high, so no access is held in wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[REG_SEL_BIT];

  always_comb begin
    cfg_prdata = '0;
    case (reg_sel)
      REG_POOL_SIZE: cfg_prdata = PDATA_W'(pool_size_r);
      REG_COOLDOWN:  cfg_prdata = PDATA_W'(cooldown_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // The pool never grows past the storage, and a load too large for a countdown saturates.
  assign pool_ext  = SZ_W'(pool_size_r);
  assign size_clip = (pool_ext > SZ_W'(MAX_ENTRIES)) ? SZ_W'(MAX_ENTRIES) : pool_ext;
  assign size      = CNT_W'(size_clip);
  assign load_ext  = LD_W'(cooldown_r);
  assign load_val  = (load_ext > LD_W'(TIMER_MAX)) ? TIMER_MAX : TIMER_WIDTH'(load_ext);

  assign in_req.ready  = (state_r == ST_IDLE);
  assign in_fire       = in_req.valid && in_req.ready;
  assign entry_in_pool = CMP_W'(in_req.entry_index) < CMP_W'(size);

  // The scan position never reaches MAX_ENTRIES + 1, so the increment cannot overflow.
  assign pos_inc  = pos_r + CNT_W'(1);
  assign pos_wrap = (pos_inc == size) ? '0 : pos_inc;

  assign out_res.valid        = out_valid_r;
  assign out_res.found        = out_found_r;
  assign out_res.picked_index = out_idx_r;

  rrpc_cd_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (bank_cmd),
    .rd_zero (bank_zero)
  );

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    next_start_nxt = next_start_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_idx_nxt    = out_idx_r;
    pool_size_nxt  = pool_size_r;
    cooldown_nxt   = cooldown_r;
    bank_cmd.op    = BANK_NOP;
    bank_cmd.idx   = pos_r[IDX_W-1:0];
    bank_cmd.load  = load_val;

    if (cfg_wr) begin
      case (reg_sel)
        REG_POOL_SIZE: pool_size_nxt = cfg_pwdata[POOL_W-1:0];
        REG_COOLDOWN:  cooldown_nxt  = cfg_pwdata[COOL_W-1:0];
        default:       ;
      endcase
    end

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req.req_type)
            REQ_PICK: begin
              if (size == '0) begin
                // Empty pool: answer none found right away.
                res_found_nxt = 1'b0;
                res_idx_nxt   = '0;
                state_nxt     = ST_EMIT;
              end else begin
                pos_nxt   = CNT_W'(next_start_r);
                cnt_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            REQ_MARK: begin
              if (entry_in_pool) begin
                bank_cmd.op  = BANK_LOAD;
                bank_cmd.idx = IDX_W'(in_req.entry_index);
              end
            end
            REQ_TICK: begin
              pos_nxt   = '0;
              state_nxt = ST_TICK;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (pos_r >= size) begin
          // The pool shrank below the cursor: reduce it modulo the size, one subtract a cycle.
          pos_nxt = pos_r - size;
        end else if (bank_zero) begin
          res_found_nxt  = 1'b1;
          res_idx_nxt    = PICK_W'(pos_r);
          next_start_nxt = IDX_W'(pos_wrap);
          state_nxt      = ST_EMIT;
        end else if (cnt_r == size - CNT_W'(1)) begin
          // Every entry in the pool is cooling; the cursor stays where it was.
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          state_nxt     = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          pos_nxt = pos_wrap;
        end
      end

      ST_TICK: begin
        // All entries count down, including those outside the pool.
        bank_cmd.op = BANK_DEC;
        if (pos_r == CNT_W'(MAX_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_inc;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_start_r <= '0;
      out_valid_r  <= 1'b0;
      pool_size_r  <= '0;
      cooldown_r   <= COOLDOWN_RESET;
    end else begin
      state_r      <= state_nxt;
      next_start_r <= next_start_nxt;
      out_valid_r  <= out_valid_nxt;
      pool_size_r  <= pool_size_nxt;
      cooldown_r   <= cooldown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

endmodule

// File: hdl/rrpc_checker.sv
// Port-level checks for the round robin picker with cooldown, bound to the top level.
// Depends on rrpc_pkg and round_robin_picker_with_cooldown.
module rrpc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [rrpc_pkg::REQ_W-1:0]  in_req_type,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [rrpc_pkg::PICK_W-1:0] out_picked_index
);
  import rrpc_pkg::*;

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A miss always reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_picked_index == '0)
    else $error("none found with a nonzero index");

  // A pick occupies the sequencer, so no request is taken in the next cycle.
  a_pick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_PICK |=> !in_ready)
    else $error("request taken right after a pick");

  // A mark completes in its own cycle.
  a_mark_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_MARK |=> in_ready)
    else $error("mark held the request channel");

  // Reset leaves no result word pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered after reset");

endmodule

bind round_robin_picker_with_cooldown rrpc_checker u_rrpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .in_req_type      (in_req.req_type),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_found        (out_res.found),
  .out_picked_index (out_res.picked_index)
);
